// ===== sv/rbbs_pkg.sv =====
package rbbs_pkg;

  // Field widths
  localparam int POS_W  = 16;  // position as reported on the ports
  localparam int TOT_W  = 17;  // total length and internal positions
  localparam int CNT_W  = 17;  // sample count and block sizes
  localparam int OCC_W  = 18;  // signed occupancy
  localparam int REG_W  = 16;  // configuration register width
  localparam int CIDX_W = 2;   // configuration index width
  localparam int OP_W   = 3;

  // Default limit on buffer length plus pre-delay
  localparam int MAX_TOTAL_LENGTH_DEF = 65536;

  // Reset values of the configuration registers
  localparam logic [REG_W-1:0] BUF_LEN_RESET   = 16'd1024;
  localparam logic [REG_W-1:0] PRE_DELAY_RESET = 16'd0;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_BUFFER_LENGTH = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_PRE_DELAY     = 2'd1;

  // Occupancy saturation bounds
  localparam logic signed [OCC_W-1:0] OCC_MAX = 18'sh1FFFF;
  localparam logic signed [OCC_W-1:0] OCC_MIN = 18'sh20000;

  typedef enum logic [OP_W-1:0] {
    OP_STORE    = 3'd0,
    OP_RETRIEVE = 3'd1,
    OP_SKIP     = 3'd2,
    OP_LOOK     = 3'd3,
    OP_RESET    = 3'd4
  } op_t;

  // Configuration view handed to the pointer engine
  typedef struct packed {
    logic [TOT_W-1:0] total;  // effective total length
    logic [TOT_W-1:0] home;   // write position after a position reset
    logic             clear;  // read position and count return to zero, write position to home
  } cfg_info_t;

endpackage

// ===== sv/rbbs_cfg.sv =====
module rbbs_cfg #(
  parameter int MAX_TOTAL_LENGTH = rbbs_pkg::MAX_TOTAL_LENGTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rbbs_pkg::CIDX_W-1:0] cfg_index,
  input  logic [rbbs_pkg::REG_W-1:0]  cfg_wdata,
  output rbbs_pkg::cfg_info_t         cfg_info
);
  import rbbs_pkg::*;

  // Largest possible sum of the two registers is 131070, so a clamp above that never acts
  localparam int TClampInt = (MAX_TOTAL_LENGTH < 131071) ? MAX_TOTAL_LENGTH : 131071;
  localparam logic [TOT_W-1:0] TClamp = TOT_W'(TClampInt);
  localparam int TResetInt = (TClampInt < 1024) ? TClampInt : 1024;

  // Pre-delay can reach the total length only when the limit is below 65536
  localparam bit SmallMax = (MAX_TOTAL_LENGTH < 65536);
  localparam longint unsigned ModDiv = SmallMax ? longint'(MAX_TOTAL_LENGTH) : 64'd1;
  localparam longint unsigned Recip  = ((64'd1 << 32) + ModDiv - 64'd1) / ModDiv;

  logic [REG_W-1:0] buf_len_r, buf_len_nxt;
  logic [REG_W-1:0] pre_delay_r, pre_delay_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [REG_W-1:0] pd_mod_r, pd_mod_nxt;
  logic             clear_r, clear_nxt;
  logic [REG_W-1:0] eff_len;
  logic [TOT_W-1:0] sum;
  logic [47:0]      recip_prod;
  logic [REG_W-1:0] quot;
  logic [31:0]      quot_mul;

  // Register write decode
  always_comb begin
    buf_len_nxt   = buf_len_r;
    pre_delay_nxt = pre_delay_r;
    clear_nxt     = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUFFER_LENGTH: begin
          buf_len_nxt = cfg_wdata;
          clear_nxt   = 1'b1;
        end
        CFG_PRE_DELAY: begin
          pre_delay_nxt = cfg_wdata;
          clear_nxt     = 1'b1;
        end
        default: clear_nxt = 1'b0;
      endcase
    end
  end

  // Total length: zero buffer length counts as one, then the limit
  assign eff_len   = (buf_len_nxt == '0) ? REG_W'(1) : buf_len_nxt;
  assign sum       = TOT_W'(eff_len) + TOT_W'(pre_delay_nxt);
  assign total_nxt = (sum > TClamp) ? TClamp : sum;

  // Pre-delay modulo the limit, by reciprocal (exact for 16-bit operands)
  assign recip_prod = 48'(pre_delay_nxt) * 48'(Recip);
  assign quot       = recip_prod[47:32];
  assign quot_mul   = 32'(quot) * 32'(ModDiv);
  assign pd_mod_nxt = SmallMax ? (pre_delay_nxt - quot_mul[REG_W-1:0]) : pre_delay_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_len_r   <= BUF_LEN_RESET;
      pre_delay_r <= PRE_DELAY_RESET;
      total_r     <= TOT_W'(TResetInt);
      pd_mod_r    <= PRE_DELAY_RESET;
      clear_r     <= 1'b0;
    end else begin
      buf_len_r   <= buf_len_nxt;
      pre_delay_r <= pre_delay_nxt;
      total_r     <= total_nxt;
      pd_mod_r    <= pd_mod_nxt;
      clear_r     <= clear_nxt;
    end
  end

  // Home write position is pre-delay mod total
  assign cfg_info.total = total_r;
  assign cfg_info.home  = (TOT_W'(pre_delay_r) < total_r) ? TOT_W'(pre_delay_r)
                                                          : TOT_W'(pd_mod_r);
  assign cfg_info.clear = clear_r;

  // Assertions
  a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    total_r != '0)
    else $error("total length is zero");
  a_total_limit: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TClamp)
    else $error("total length above limit");
  a_home_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_info.home < total_r)
    else $error("home position outside buffer");
  a_clear_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == CFG_BUFFER_LENGTH || cfg_index == CFG_PRE_DELAY) |=> clear_r)
    else $error("register write did not reset positions");

endmodule

// ===== sv/rbbs_engine.sv =====
module rbbs_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rbbs_pkg::cfg_info_t               cfg_info,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rbbs_pkg::OP_W-1:0]         in_op,
  input  logic [rbbs_pkg::CNT_W-1:0]        in_sample_count,
  input  logic                              in_commit,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rbbs_pkg::POS_W-1:0]        out_first_start,
  output logic [rbbs_pkg::CNT_W-1:0]        out_first_size,
  output logic [rbbs_pkg::CNT_W-1:0]        out_second_size,
  output logic [rbbs_pkg::POS_W-1:0]        out_read_position,
  output logic [rbbs_pkg::POS_W-1:0]        out_write_position,
  output logic signed [rbbs_pkg::OCC_W-1:0] out_stored_count,
  output logic                              out_overrun,
  output logic                              out_underrun,
  output logic                              out_bad_request
);
  import rbbs_pkg::*;

  // Input stage
  logic             s1_valid_r, s1_valid_nxt;
  logic [OP_W-1:0]  op_r;
  logic [CNT_W-1:0] n_r;
  logic             commit_r;

  // Position and count state
  logic [TOT_W-1:0]        rd_r, rd_nxt;
  logic [TOT_W-1:0]        wr_r, wr_nxt;
  logic signed [OCC_W-1:0] occ_r, occ_nxt;

  // Result stage
  logic                    out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]        start_r;
  logic [CNT_W-1:0]        size1_r, size2_r;
  logic [POS_W-1:0]        rdpos_r, wrpos_r;
  logic signed [OCC_W-1:0] occ_out_r;
  logic                    ovr_r, und_r, bad_r;

  logic             in_fire, adv, fire1;
  logic [TOT_W-1:0] t;
  logic             bad, blocks, ovr, und;
  logic [TOT_W-1:0] base, room;
  logic [CNT_W-1:0] size1, size2;
  logic [TOT_W:0]   wr_adv, rd_adv, lb_sum;
  logic [TOT_W-1:0] wr_wrap, rd_wrap, lb_start;
  logic signed [OCC_W:0]   occ_plus, occ_minus, t_s;
  logic signed [OCC_W-1:0] occ_inc, occ_dec;

  // Handshake: the result register stalls the input stage only when both are full
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv;
  assign in_fire  = in_valid && in_ready;
  assign fire1    = s1_valid_r && adv;

  assign t = cfg_info.total;

  // Advanced positions, one conditional subtract each
  assign wr_adv  = {1'b0, wr_r} + {1'b0, n_r};
  assign wr_wrap = (wr_adv >= {1'b0, t}) ? TOT_W'(wr_adv - {1'b0, t}) : wr_adv[TOT_W-1:0];
  assign rd_adv  = {1'b0, rd_r} + {1'b0, n_r};
  assign rd_wrap = (rd_adv >= {1'b0, t}) ? TOT_W'(rd_adv - {1'b0, t}) : rd_adv[TOT_W-1:0];
  assign lb_sum  = {1'b0, wr_r} + {1'b0, TOT_W'(t - n_r)};
  assign lb_start = (lb_sum >= {1'b0, t}) ? TOT_W'(lb_sum - {1'b0, t})
                                          : lb_sum[TOT_W-1:0];

  // Saturating count updates
  assign occ_plus  = $signed({occ_r[OCC_W-1], occ_r}) + $signed({2'b00, n_r});
  assign occ_minus = $signed({occ_r[OCC_W-1], occ_r}) - $signed({2'b00, n_r});
  assign occ_inc   = (occ_plus > $signed({2'b00, OCC_MAX[OCC_W-2:0]})) ? OCC_MAX
                                                                       : occ_plus[OCC_W-1:0];
  assign occ_dec   = (occ_minus < $signed({OCC_MIN[OCC_W-1], OCC_MIN})) ? OCC_MIN
                                                                        : occ_minus[OCC_W-1:0];
  assign t_s       = $signed({2'b00, t});

  // Request decode and state update
  always_comb begin
    rd_nxt  = rd_r;
    wr_nxt  = wr_r;
    occ_nxt = occ_r;
    base    = '0;
    blocks  = 1'b0;
    ovr     = 1'b0;
    und     = 1'b0;
    bad     = 1'b0;
    unique case (op_r)
      OP_STORE: begin
        bad = (n_r > t);
        if (!bad) begin
          base   = wr_r;
          blocks = 1'b1;
          if (commit_r) begin
            wr_nxt  = wr_wrap;
            occ_nxt = occ_inc;
            ovr     = ($signed({occ_inc[OCC_W-1], occ_inc}) > t_s);
          end
        end
      end
      OP_RETRIEVE: begin
        bad = (n_r > t);
        if (!bad) begin
          base   = rd_r;
          blocks = 1'b1;
          if (commit_r) begin
            rd_nxt  = rd_wrap;
            occ_nxt = occ_dec;
            und     = occ_dec[OCC_W-1];
          end
        end
      end
      OP_SKIP: begin
        bad = (n_r > t);
        if (!bad) begin
          rd_nxt  = rd_wrap;
          occ_nxt = occ_dec;
          und     = occ_dec[OCC_W-1];
        end
      end
      OP_LOOK: begin
        bad = (n_r > t);
        if (!bad) begin
          base   = lb_start;
          blocks = 1'b1;
        end
      end
      OP_RESET: begin
        rd_nxt  = '0;
        wr_nxt  = cfg_info.home;
        occ_nxt = '0;
      end
      default: bad = 1'b0;
    endcase
  end

  // Two-block split at the buffer end
  assign room  = t - base;
  assign size1 = blocks ? ((n_r < room) ? n_r : room) : '0;
  assign size2 = blocks ? (n_r - size1) : '0;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (fire1) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire1) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rd_r        <= '0;
      wr_r        <= '0;
      occ_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_info.clear) begin
        rd_r  <= '0;
        wr_r  <= cfg_info.home;
        occ_r <= '0;
      end else if (fire1) begin
        rd_r  <= rd_nxt;
        wr_r  <= wr_nxt;
        occ_r <= occ_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_op;
      n_r      <= in_sample_count;
      commit_r <= in_commit;
    end
    if (fire1) begin
      start_r   <= base[POS_W-1:0];
      size1_r   <= size1;
      size2_r   <= size2;
      rdpos_r   <= rd_nxt[POS_W-1:0];
      wrpos_r   <= wr_nxt[POS_W-1:0];
      occ_out_r <= occ_nxt;
      ovr_r     <= ovr;
      und_r     <= und;
      bad_r     <= bad;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_first_start    = start_r;
  assign out_first_size     = size1_r;
  assign out_second_size    = size2_r;
  assign out_read_position  = rdpos_r;
  assign out_write_position = wrpos_r;
  assign out_stored_count   = occ_out_r;
  assign out_overrun        = ovr_r;
  assign out_underrun       = und_r;
  assign out_bad_request    = bad_r;

  // Assertions
  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_info.clear || (rd_r < t))
    else $error("read position outside buffer");
  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_info.clear || (wr_r < t))
    else $error("write position outside buffer");
  a_bad_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
    fire1 && bad && !cfg_info.clear |=> $stable(rd_r) && $stable(wr_r) && $stable(occ_r))
    else $error("rejected request changed state");
  a_bad_no_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && bad_r |-> (size1_r == '0) && (size2_r == '0) && !ovr_r && !und_r)
    else $error("rejected request reported blocks or flags");
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire1 |=> out_valid_r)
    else $error("processed request produced no result");

endmodule

// ===== sv/ring_buffer_block_splitter_top.sv =====
// Ring buffer block splitter: position keeper for a circular sample buffer
// whose total length is buffer length plus pre-delay.
//
// Request channel (in_*): valid/ready; op, sample_count, commit. One result
// (out_*) comes back per request, carrying the first block start and size,
// the wrapped second block size (always from index 0), the positions and
// signed count after the request, and the overrun/underrun/bad flags.
// Configuration (cfg_*): write enable, register index, 16-bit data; index 0
// is buffer length, 1 is pre-delay. A write to index 0 or 1 also resets the
// positions and the count via a clear registered in the config block.
//
// A request passes an input register, then one pass of add, compare and
// conditional subtract against the total length into the result register.
// One request per cycle is sustained while the receiver takes every result.
// Reset loads buffer length 1024, pre-delay 0, both positions and the count 0.
// When the receiver stalls, the result register holds and the input register
// takes one more request; ready falls only when both are full.
module ring_buffer_block_splitter_top #(
  parameter int MAX_TOTAL_LENGTH = rbbs_pkg::MAX_TOTAL_LENGTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rbbs_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [rbbs_pkg::REG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rbbs_pkg::OP_W-1:0]         in_op,
  input  logic [rbbs_pkg::CNT_W-1:0]        in_sample_count,
  input  logic                              in_commit,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rbbs_pkg::POS_W-1:0]        out_first_start,
  output logic [rbbs_pkg::CNT_W-1:0]        out_first_size,
  output logic [rbbs_pkg::CNT_W-1:0]        out_second_size,
  output logic [rbbs_pkg::POS_W-1:0]        out_read_position,
  output logic [rbbs_pkg::POS_W-1:0]        out_write_position,
  output logic signed [rbbs_pkg::OCC_W-1:0] out_stored_count,
  output logic                              out_overrun,
  output logic                              out_underrun,
  output logic                              out_bad_request
);
  import rbbs_pkg::*;

  cfg_info_t cfg_info;

  // Configuration registers, total length and home position
  rbbs_cfg #(
    .MAX_TOTAL_LENGTH(MAX_TOTAL_LENGTH)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg_info (cfg_info)
  );

  // Request pipeline and position state
  rbbs_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_info          (cfg_info),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_sample_count   (in_sample_count),
    .in_commit         (in_commit),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_first_start   (out_first_start),
    .out_first_size    (out_first_size),
    .out_second_size   (out_second_size),
    .out_read_position (out_read_position),
    .out_write_position(out_write_position),
    .out_stored_count  (out_stored_count),
    .out_overrun       (out_overrun),
    .out_underrun      (out_underrun),
    .out_bad_request   (out_bad_request)
  );

endmodule
